// ----- hw/rtl/frkc_pkg.sv -----
`timescale 1ns / 1ps

package frkc_pkg;

    // Field widths fixed by the item format
    localparam int COUNT_W = 18;
    localparam int CFG_W   = 18;
    localparam int SLOT_W  = 4;
    localparam int FILL_W  = 5;

    // Reset values of the limit registers
    localparam logic [CFG_W-1:0] RST_MAX_FACES    = 18'd50000;
    localparam logic [CFG_W-1:0] RST_MAX_EDGES    = 18'd200000;
    localparam logic [CFG_W-1:0] RST_MAX_VERTICES = 18'd100000;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_STORE  = 2'd1,
        OP_EVICT  = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        REG_MAX_FACES    = 2'd0,
        REG_MAX_EDGES    = 2'd1,
        REG_MAX_VERTICES = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_MISS   = 2'd1,
        ST_REJECT = 2'd2
    } t_status;

    // Command as it travels down the chain of cells
    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_LOOKUP,
        CMD_STORE,
        CMD_EVICT,
        CMD_CLEAR,
        CMD_REJECT
    } t_cmd;

    // Key of six request fields in five struct fields, grid packed as {grid_y, grid_x}
    typedef struct packed {
        logic [31:0] grid;
        logic [31:0] tile;
        logic [7:0]  jtype;
        logic [31:0] box;
        logic [31:0] bldg;
    } t_key;

    // Control group handed from cell to cell
    typedef struct packed {
        logic valid;
        t_cmd cmd;
        logic found;
    } t_tok_ctl;

endpackage

// ----- hw/rtl/frkc_req_if.sv -----
`timescale 1ns / 1ps

interface frkc_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [15:0] grid_x;
    logic signed [15:0] grid_y;
    logic [31:0]        tile_id;
    logic [7:0]         job_type;
    logic [31:0]        box_hash;
    logic [31:0]        building_hash;
    logic [17:0]        face_count;
    logic [17:0]        edge_count;
    logic [17:0]        vertex_count;
    logic [3:0]         slot;

    modport source (
        output valid, opcode, grid_x, grid_y, tile_id, job_type, box_hash,
               building_hash, face_count, edge_count, vertex_count, slot,
        input  ready
    );
    modport sink (
        input  valid, opcode, grid_x, grid_y, tile_id, job_type, box_hash,
               building_hash, face_count, edge_count, vertex_count, slot,
        output ready
    );
endinterface

// ----- hw/rtl/frkc_rsp_if.sv -----
`timescale 1ns / 1ps

interface frkc_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [3:0] hit_slot;
    logic [4:0] fill_count;

    modport source (
        output valid, status, hit_slot, fill_count,
        input  ready
    );
    modport sink (
        input  valid, status, hit_slot, fill_count,
        output ready
    );
endinterface

// ----- hw/rtl/frkc_cell.sv -----
`timescale 1ns / 1ps

// One cache entry plus one pipeline slot of the command chain.
module frkc_cell #(
    parameter int CELL_IDX = 0,
    parameter int AW       = 4,
    parameter int FW       = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  frkc_pkg::t_tok_ctl  i_ctl,
    input  frkc_pkg::t_key      i_key,
    input  logic [AW-1:0]       i_idx,
    input  logic [FW-1:0]       i_fill,
    output frkc_pkg::t_tok_ctl  o_ctl,
    output frkc_pkg::t_key      o_key,
    output logic [AW-1:0]       o_idx,
    output logic [FW-1:0]       o_fill
);

    localparam logic [AW-1:0] MY_SLOT = CELL_IDX[AW-1:0];

    frkc_pkg::t_tok_ctl r_ctl, n_ctl;
    frkc_pkg::t_key     r_key;
    logic [AW-1:0]      r_idx, n_idx;
    logic [FW-1:0]      r_fill;
    logic               r_ent_valid, n_ent_valid;
    frkc_pkg::t_key     r_ent_key;
    logic               hit;
    logic               targeted;
    logic               ent_wr;

    assign hit      = r_ent_valid && (r_ent_key == i_key);
    assign targeted = (i_idx == MY_SLOT);
    assign ent_wr   = i_adv && i_ctl.valid && (i_ctl.cmd == frkc_pkg::CMD_STORE) && targeted;

    // Lookup: first matching cell along the chain claims the hit (lowest slot)
    always_comb begin
        n_ctl = i_ctl;
        n_idx = i_idx;
        if (i_ctl.valid && (i_ctl.cmd == frkc_pkg::CMD_LOOKUP) && !i_ctl.found && hit) begin
            n_ctl.found = 1'b1;
            n_idx       = MY_SLOT;
        end
    end

    // Entry valid bit update
    always_comb begin
        n_ent_valid = r_ent_valid;
        if (i_adv && i_ctl.valid) begin
            case (i_ctl.cmd)
                frkc_pkg::CMD_STORE: if (targeted) n_ent_valid = 1'b1;
                frkc_pkg::CMD_EVICT: if (targeted) n_ent_valid = 1'b0;
                frkc_pkg::CMD_CLEAR: n_ent_valid = 1'b0;
                default:             n_ent_valid = r_ent_valid;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl       <= '0;
            r_ent_valid <= 1'b0;
        end else begin
            r_ent_valid <= n_ent_valid;
            if (i_adv) begin
                r_ctl <= n_ctl;
            end
        end
    end

    // Payload and stored key
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_key  <= i_key;
            r_idx  <= n_idx;
            r_fill <= i_fill;
        end
        if (ent_wr) begin
            r_ent_key <= i_key;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_key  = r_key;
    assign o_idx  = r_idx;
    assign o_fill = r_fill;

    // A store leaves its target entry valid
    a_store_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ent_wr |=> r_ent_valid)
        else $error("store did not set entry valid");

    // A clear drops the entry
    a_clear_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_ctl.valid && (i_ctl.cmd == frkc_pkg::CMD_CLEAR)) |=> !r_ent_valid)
        else $error("clear left entry valid");

    // A hit claimed here carries this cell's slot
    a_hit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_ctl.valid && (i_ctl.cmd == frkc_pkg::CMD_LOOKUP) && !i_ctl.found && hit)
        |=> (r_ctl.found && (r_idx == MY_SLOT)))
        else $error("hit slot not recorded");

endmodule

// ----- hw/rtl/fifo_replacement_key_cache_unit.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// i_req     in   valid / ready      opcode, key fields, counts, slot
// o_rsp     out  valid / ready      status, hit_slot, fill_count
// i_cfg_*   in   write enable only  register index, 18-bit data
//
// A command walks the row of entry cells, registered in each cell in turn,
// so commands stay in order against the entries they touch.
// One item is accepted per cycle while no response is held.
// A stalled response freezes the whole chain and drops i_req.ready.
// Synchronous active-low reset clears all valid bits, pointer and fill level.
module fifo_replacement_key_cache_unit #(
    parameter int CACHE_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [frkc_pkg::CFG_W-1:0] i_cfg_data,
    frkc_req_if.sink                   i_req,
    frkc_rsp_if.source                 o_rsp
);

    localparam int AW = $clog2(CACHE_DEPTH);
    localparam int FW = $clog2(CACHE_DEPTH + 1);

    logic [frkc_pkg::CFG_W-1:0] r_max_faces, r_max_edges, r_max_vertices;
    logic [AW-1:0]              r_wp, n_wp;
    logic [FW-1:0]              r_fill, n_fill;

    frkc_pkg::t_tok_ctl chain_ctl  [CACHE_DEPTH+1];
    frkc_pkg::t_key     chain_key  [CACHE_DEPTH+1];
    logic [AW-1:0]      chain_idx  [CACHE_DEPTH+1];
    logic [FW-1:0]      chain_fill [CACHE_DEPTH+1];

    logic               adv;
    logic               accept;
    logic               over_limit;
    logic               slot_ok;
    logic [AW+3:0]      slot_ext;
    frkc_pkg::t_cmd     head_cmd;
    frkc_pkg::t_tok_ctl last_ctl;
    logic [AW+3:0]      hit_ext;
    logic [FW+4:0]      fill_ext;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_faces    <= frkc_pkg::RST_MAX_FACES;
            r_max_edges    <= frkc_pkg::RST_MAX_EDGES;
            r_max_vertices <= frkc_pkg::RST_MAX_VERTICES;
        end else if (i_cfg_we) begin
            case (frkc_pkg::t_reg_idx'(i_cfg_idx))
                frkc_pkg::REG_MAX_FACES:    r_max_faces    <= i_cfg_data;
                frkc_pkg::REG_MAX_EDGES:    r_max_edges    <= i_cfg_data;
                frkc_pkg::REG_MAX_VERTICES: r_max_vertices <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Chain moves unless the response is held
    assign adv         = !last_ctl.valid || o_rsp.ready;
    assign i_req.ready = adv;
    assign accept      = i_req.valid && adv;

    assign over_limit = (i_req.face_count > r_max_faces) ||
                        (i_req.edge_count > r_max_edges) ||
                        (i_req.vertex_count > r_max_vertices);
    assign slot_ext   = {{AW{1'b0}}, i_req.slot};
    assign slot_ok    = ({5'd0, i_req.slot} < 9'(CACHE_DEPTH));

    // Head decode: command, write pointer and fill level
    always_comb begin
        head_cmd = frkc_pkg::CMD_NOP;
        n_wp     = r_wp;
        n_fill   = r_fill;
        case (frkc_pkg::t_opcode'(i_req.opcode))
            frkc_pkg::OP_LOOKUP: head_cmd = frkc_pkg::CMD_LOOKUP;
            frkc_pkg::OP_STORE: begin
                if (over_limit) begin
                    head_cmd = frkc_pkg::CMD_REJECT;
                end else begin
                    head_cmd = frkc_pkg::CMD_STORE;
                    n_wp     = (r_wp == AW'(CACHE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                    n_fill   = (r_fill < FW'(CACHE_DEPTH)) ? r_fill + 1'b1 : r_fill;
                end
            end
            frkc_pkg::OP_EVICT: head_cmd = slot_ok ? frkc_pkg::CMD_EVICT : frkc_pkg::CMD_NOP;
            frkc_pkg::OP_CLEAR: begin
                head_cmd = frkc_pkg::CMD_CLEAR;
                n_wp     = '0;
                n_fill   = '0;
            end
            default: head_cmd = frkc_pkg::CMD_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
        end else if (accept) begin
            r_wp   <= n_wp;
            r_fill <= n_fill;
        end
    end

    // Token entering the first cell
    always_comb begin
        chain_ctl[0].valid = accept;
        chain_ctl[0].cmd   = head_cmd;
        chain_ctl[0].found = 1'b0;
        chain_key[0].grid  = {i_req.grid_y, i_req.grid_x};
        chain_key[0].tile  = i_req.tile_id;
        chain_key[0].jtype = i_req.job_type;
        chain_key[0].box   = i_req.box_hash;
        chain_key[0].bldg  = i_req.building_hash;
        chain_idx[0]       = (head_cmd == frkc_pkg::CMD_EVICT) ? slot_ext[AW-1:0] : r_wp;
        chain_fill[0]      = n_fill;
    end

    // Row of entry cells
    for (genvar g = 0; g < CACHE_DEPTH; g++) begin : g_cell
        frkc_cell #(
            .CELL_IDX (g),
            .AW       (AW),
            .FW       (FW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (adv),
            .i_ctl  (chain_ctl[g]),
            .i_key  (chain_key[g]),
            .i_idx  (chain_idx[g]),
            .i_fill (chain_fill[g]),
            .o_ctl  (chain_ctl[g+1]),
            .o_key  (chain_key[g+1]),
            .o_idx  (chain_idx[g+1]),
            .o_fill (chain_fill[g+1])
        );
    end

    // Response from the last cell
    assign last_ctl = chain_ctl[CACHE_DEPTH];
    assign fill_ext = {5'd0, chain_fill[CACHE_DEPTH]};

    always_comb begin
        hit_ext = '0;
        case (last_ctl.cmd)
            frkc_pkg::CMD_LOOKUP: begin
                o_rsp.status = last_ctl.found ? frkc_pkg::ST_DONE : frkc_pkg::ST_MISS;
                if (last_ctl.found) hit_ext = {4'd0, chain_idx[CACHE_DEPTH]};
            end
            frkc_pkg::CMD_STORE: begin
                o_rsp.status = frkc_pkg::ST_DONE;
                hit_ext      = {4'd0, chain_idx[CACHE_DEPTH]};
            end
            frkc_pkg::CMD_REJECT: o_rsp.status = frkc_pkg::ST_REJECT;
            default:              o_rsp.status = frkc_pkg::ST_DONE;
        endcase
    end

    assign o_rsp.valid      = last_ctl.valid;
    assign o_rsp.hit_slot   = hit_ext[3:0];
    assign o_rsp.fill_count = fill_ext[4:0];

    // Fill level never passes the depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(CACHE_DEPTH))
        else $error("fill level above depth");

    // An accepted clear rewinds pointer and fill level
    a_clear_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.opcode == frkc_pkg::OP_CLEAR)) |=> (r_wp == '0 && r_fill == '0))
        else $error("clear did not rewind");

    // A miss reports slot zero
    a_miss_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == frkc_pkg::ST_MISS) |-> (o_rsp.hit_slot == 4'd0))
        else $error("miss with nonzero slot");

    // A held response blocks new transfers
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |-> !i_req.ready)
        else $error("input taken while response held");

endmodule
